// ===== rtl/core/cbm_pkg.sv =====
// Shared types, constants and address decode helpers for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

	// One input item: a CPU register write or a scanline tick.
	typedef struct packed {
		logic        cmd;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [9:0]  cycles;
	} in_item_t;

	// One result item: the bank map after the item and its IRQ count.
	typedef struct packed {
		logic [4:0]  prg_bank_8000;
		logic [4:0]  prg_bank_a000;
		logic [4:0]  prg_bank_c000;
		logic [63:0] chr_banks;
		logic        mirroring;
		logic [8:0]  irq_fired;
	} out_item_t;

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_STEP
	} cbm_state_t;

	// Strobes from the sequencer to the IRQ unit.
	typedef struct packed {
		logic exec;
		logic step;
	} irq_ctl_t;

	// Status from the IRQ unit back to the sequencer.
	typedef struct packed {
		logic more;
	} irq_sts_t;

	localparam logic       CMD_WRITE = 1'b0;
	localparam logic       CMD_TICK  = 1'b1;

	localparam logic [11:0] LINE_CYCLES  = 12'd341;
	localparam logic [4:0]  FIXED_BANK   = 5'h1E;
	localparam logic [9:0]  CYCLES_PER_STEP = 10'd3;

	// Address pages (addr[15:12]).
	localparam logic [3:0] PAGE_PRG_FIRST  = 4'h8;
	localparam logic [3:0] PAGE_MIRROR     = 4'h9;
	localparam logic [3:0] PAGE_PRG_SECOND = 4'hA;
	localparam logic [3:0] PAGE_CHR_B      = 4'hB;
	localparam logic [3:0] PAGE_CHR_C      = 4'hC;
	localparam logic [3:0] PAGE_CHR_D      = 4'hD;
	localparam logic [3:0] PAGE_CHR_E      = 4'hE;
	localparam logic [3:0] PAGE_IRQ        = 4'hF;

	// Sub-register codes.
	localparam logic [1:0] SEL_MIRROR   = 2'd0;
	localparam logic [1:0] SEL_SWAP     = 2'd1;
	localparam logic [1:0] SEL_LATCH_LO = 2'd0;
	localparam logic [1:0] SEL_CONTROL  = 2'd1;
	localparam logic [1:0] SEL_LATCH_HI = 2'd2;
	localparam logic [1:0] SEL_ACK      = 2'd3;

	// Wiring variants a..e.
	localparam logic [2:0] VARIANT_A = 3'd0;
	localparam logic [2:0] VARIANT_B = 3'd1;
	localparam logic [2:0] VARIANT_C = 3'd2;
	localparam logic [2:0] VARIANT_D = 3'd3;
	localparam logic [2:0] VARIANT_E = 3'd4;

	// Reorder tables, element r gives the sub-register for raw address bits r.
	localparam logic [3:0][1:0] MAP_SWAPPED  = {2'd3, 2'd1, 2'd2, 2'd0};
	localparam logic [3:0][1:0] MAP_STRAIGHT = {2'd3, 2'd2, 2'd1, 2'd0};

	// Sub-register select for a write address under a wiring variant.
	// Unknown variant codes fall back to wiring a.
	function automatic logic [1:0] sub_sel(logic [2:0] variant, logic [15:0] addr);
		logic [1:0] raw;
		logic [3:0][1:0] map;
		raw = addr[2:1];
		map = MAP_SWAPPED;
		case (variant)
			VARIANT_B: begin
				raw = addr[1:0];
				map = MAP_STRAIGHT;
			end
			VARIANT_C: begin
				raw = addr[7:6];
				map = MAP_SWAPPED;
			end
			VARIANT_D: begin
				raw = addr[3:2];
				map = MAP_STRAIGHT;
			end
			VARIANT_E: begin
				raw = addr[3:2];
				map = MAP_SWAPPED;
			end
			default: begin
				raw = addr[2:1];
				map = MAP_SWAPPED;
			end
		endcase
		return map[raw];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cbm_regs.sv =====
// Program bank, character bank and mirroring registers with their write decode.
`default_nettype none

module cbm_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [15:0] addr,
	input  wire logic [7:0]  data,
	input  wire logic [2:0]  variant,
	output logic [4:0]       prg_first,
	output logic [4:0]       prg_second,
	output logic             prg_swap,
	output logic [63:0]      chr_banks,
	output logic             mirror
);

	logic [4:0] prg_first_q;
	logic [4:0] prg_second_q;
	logic       prg_swap_q;
	logic       mirror_q;
	logic [7:0] chr_q [8];

	logic [1:0] sel;
	logic [3:0] page;
	logic [3:0] chr_page_off;
	logic [2:0] chr_idx;

	assign sel          = cbm_pkg::sub_sel(variant, addr);
	assign page         = addr[15:12];
	assign chr_page_off = page - cbm_pkg::PAGE_CHR_B;
	assign chr_idx      = {chr_page_off[1:0], sel[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_first_q  <= '0;
			prg_second_q <= '0;
			prg_swap_q   <= 1'b0;
			mirror_q     <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				chr_q[i] <= '0;
			end
		end else if (wr_en) begin
			case (page)
				cbm_pkg::PAGE_PRG_FIRST: begin
					prg_first_q <= data[4:0];
				end
				cbm_pkg::PAGE_MIRROR: begin
					if (sel == cbm_pkg::SEL_MIRROR) begin
						mirror_q <= data[0];
					end else if (sel == cbm_pkg::SEL_SWAP) begin
						prg_swap_q <= data[1];
					end
				end
				cbm_pkg::PAGE_PRG_SECOND: begin
					prg_second_q <= data[4:0];
				end
				cbm_pkg::PAGE_CHR_B, cbm_pkg::PAGE_CHR_C,
				cbm_pkg::PAGE_CHR_D, cbm_pkg::PAGE_CHR_E: begin
					for (int i = 0; i < 8; i++) begin
						if (chr_idx == 3'(i)) begin
							if (sel[1]) begin
								chr_q[i][7:4] <= data[3:0];
							end else begin
								chr_q[i][3:0] <= data[3:0];
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			chr_banks[8*i +: 8] = chr_q[i];
		end
	end

	assign prg_first  = prg_first_q;
	assign prg_second = prg_second_q;
	assign prg_swap   = prg_swap_q;
	assign mirror     = mirror_q;

endmodule

`default_nettype wire

// ===== rtl/core/cbm_irq.sv =====
// IRQ latch, control, prescaler and the shared counter step unit.
`default_nettype none

module cbm_irq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cbm_pkg::irq_ctl_t ctl,
	input  wire cbm_pkg::in_item_t item,
	input  wire logic [2:0]        variant,
	output cbm_pkg::irq_sts_t      sts,
	output logic [8:0]             fired
);

	logic [2:0]  control_q;
	logic [7:0]  reload_q;
	logic [7:0]  counter_q;
	logic [11:0] prescale_q;
	logic [9:0]  rem_q;
	logic [8:0]  fired_q;

	logic [1:0]  sel;
	logic        enabled;
	logic        cycle_mode;
	logic [11:0] pre_next;

	// The one step unit: increment, or reload with a wrap at 0xFF.
	logic [7:0]  step_cnt;
	logic        step_wrap;

	assign sel        = cbm_pkg::sub_sel(variant, item.addr);
	assign enabled    = control_q[1];
	assign cycle_mode = control_q[2];
	assign pre_next   = prescale_q - {2'b00, item.cycles};
	assign step_wrap  = (counter_q == 8'hFF);
	assign step_cnt   = step_wrap ? reload_q : counter_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q  <= '0;
			reload_q   <= '0;
			counter_q  <= '0;
			prescale_q <= '0;
			rem_q      <= '0;
			fired_q    <= '0;
		end else if (ctl.exec) begin
			fired_q <= '0;
			rem_q   <= '0;
			if (item.cmd == cbm_pkg::CMD_WRITE) begin
				if (item.addr[15:12] == cbm_pkg::PAGE_IRQ) begin
					case (sel)
						cbm_pkg::SEL_LATCH_LO: reload_q[3:0] <= item.data[3:0];
						cbm_pkg::SEL_LATCH_HI: reload_q[7:4] <= item.data[3:0];
						cbm_pkg::SEL_CONTROL: begin
							control_q <= item.data[2:0];
							if (item.data[1]) begin
								counter_q  <= reload_q;
								prescale_q <= cbm_pkg::LINE_CYCLES;
							end
						end
						cbm_pkg::SEL_ACK: control_q[1] <= control_q[0];
						default: begin
						end
					endcase
				end
			end else if (enabled) begin
				if (cycle_mode) begin
					rem_q <= item.cycles;
				end else if (pre_next[11]) begin
					prescale_q <= pre_next + cbm_pkg::LINE_CYCLES;
					counter_q  <= step_cnt;
					fired_q    <= {8'd0, step_wrap};
				end else begin
					prescale_q <= pre_next;
				end
			end
		end else if (ctl.step) begin
			counter_q <= step_cnt;
			fired_q   <= fired_q + {8'd0, step_wrap};
			rem_q     <= rem_q - cbm_pkg::CYCLES_PER_STEP;
		end
	end

	assign sts.more = (rem_q >= cbm_pkg::CYCLES_PER_STEP);
	assign fired    = fired_q;

endmodule

`default_nettype wire

// ===== rtl/core/cartridge_bank_mapper_with_irq.sv =====
// Top level of the cartridge bank mapper: sequencer, configuration and result register.
//
//  Channel   Direction  Handshake                 Payload
//  in        to block   in_valid / in_stall       in_item  (cbm_pkg::in_item_t)
//  out       from block out_valid / out_stall     out_item (cbm_pkg::out_item_t)
//  cfg       to block   cfg_wr_en                 cfg_wr_data (wiring variant)
//
// A CPU write or a tick in prescaler mode or with the IRQ disabled goes from transfer to
// result in order: the item is captured, then applied, then the result is loaded.
// A tick in cycle mode also runs one counter step per full CYCLES_PER_STEP in its cycles;
// the single counter step unit in cbm_irq sets how long that work lasts.
// Reset clears all mapper state, the variant and out_valid, but not the result data.
// While out_stall holds a result, the block still takes and works on the next item; it then
// waits with that item's result until the result register frees.
`default_nettype none

module cartridge_bank_mapper_with_irq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire cbm_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output cbm_pkg::out_item_t      out_item,
	input  wire logic               cfg_wr_en,
	input  wire logic [2:0]         cfg_wr_data
);

	cbm_pkg::cbm_state_t state_q;
	cbm_pkg::cbm_state_t state_next;

	cbm_pkg::in_item_t  item_q;
	cbm_pkg::out_item_t out_q;
	logic               out_valid_q;
	logic [2:0]         variant_q;

	cbm_pkg::irq_ctl_t irq_ctl;
	cbm_pkg::irq_sts_t irq_sts;

	logic        in_take;
	logic        out_load;
	logic        regs_wr;

	logic [4:0]  prg_first;
	logic [4:0]  prg_second;
	logic        prg_swap;
	logic [63:0] chr_banks;
	logic        mirror;
	logic [8:0]  irq_fired;

	// The variant register is to be written only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= cbm_pkg::VARIANT_A;
		end else if (cfg_wr_en) begin
			variant_q <= cfg_wr_data;
		end
	end

	// The block takes a new item only from the idle state.
	assign in_stall = (state_q != cbm_pkg::ST_IDLE);
	assign in_take  = in_valid && !in_stall;

	// Item register: holds the accepted transfer while it is applied.
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_q <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbm_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Sequencer: apply the item once, then run the counter step unit until fewer than
	// CYCLES_PER_STEP of the item's cycles are left, then hand the result over once the result register is free.
	always_comb begin
		state_next   = state_q;
		irq_ctl.exec = 1'b0;
		irq_ctl.step = 1'b0;
		regs_wr      = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			cbm_pkg::ST_IDLE: begin
				if (in_take) begin
					state_next = cbm_pkg::ST_EXEC;
				end
			end
			cbm_pkg::ST_EXEC: begin
				irq_ctl.exec = 1'b1;
				regs_wr      = (item_q.cmd == cbm_pkg::CMD_WRITE);
				state_next   = cbm_pkg::ST_STEP;
			end
			cbm_pkg::ST_STEP: begin
				if (irq_sts.more) begin
					irq_ctl.step = 1'b1;
				end else if (!out_valid_q || !out_stall) begin
					out_load   = 1'b1;
					state_next = cbm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = cbm_pkg::ST_IDLE;
			end
		endcase
	end

	cbm_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (regs_wr),
		.addr       (item_q.addr),
		.data       (item_q.data),
		.variant    (variant_q),
		.prg_first  (prg_first),
		.prg_second (prg_second),
		.prg_swap   (prg_swap),
		.chr_banks  (chr_banks),
		.mirror     (mirror)
	);

	cbm_irq u_irq (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (irq_ctl),
		.item    (item_q),
		.variant (variant_q),
		.sts     (irq_sts),
		.fired   (irq_fired)
	);

	// Result register: parts the output handshake from the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// With the swap flag set, the fixed bank moves from 0xC000 to 0xA000.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.prg_bank_8000 <= prg_first;
			out_q.prg_bank_a000 <= prg_swap ? cbm_pkg::FIXED_BANK : prg_second;
			out_q.prg_bank_c000 <= prg_swap ? prg_second : cbm_pkg::FIXED_BANK;
			out_q.chr_banks     <= chr_banks;
			out_q.mirroring     <= mirror;
			out_q.irq_fired     <= irq_fired;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/cbm_chk.sv =====
// Port-level checker for the cartridge bank mapper and its bind to the top level.
`default_nettype none

module cbm_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire cbm_pkg::out_item_t out_item
);

	// A stalled result stays and does not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed or dropped");

	// After a transfer in, the block is busy with that item.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block took no time over an accepted item");

	// A new result only comes out of a busy block.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

	// One of the two swappable windows always shows the fixed bank.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.prg_bank_a000 == cbm_pkg::FIXED_BANK) ||
			(out_item.prg_bank_c000 == cbm_pkg::FIXED_BANK))
		else $error("fixed program bank missing from the map");

endmodule

bind cartridge_bank_mapper_with_irq cbm_chk u_cbm_chk (.*);

`default_nettype wire
